/* sv/lav_pkg.sv */
// ---------------------------------------------------------------------------
// lav_pkg
// Shared widths, defaults and the matrix bundle type for the look-at block.
// ---------------------------------------------------------------------------
package lav_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;

    // rows 0..2 of the view matrix, [row][column]
    typedef struct packed {
        logic [2:0][3:0][DATA_W-1:0] ent;
    } frame_t;

endpackage

/* sv/lav_if.sv */
// ---------------------------------------------------------------------------
// lav_if
// Valid/ready channels: camera points in, matrix rows out.
// ---------------------------------------------------------------------------
interface lav_in_if import lav_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] eye_x;
    logic signed [DATA_W-1:0] eye_y;
    logic signed [DATA_W-1:0] eye_z;
    logic signed [DATA_W-1:0] target_x;
    logic signed [DATA_W-1:0] target_y;
    logic signed [DATA_W-1:0] target_z;

    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    output ready);
endinterface

interface lav_out_if import lav_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               row_index;
    logic signed [DATA_W-1:0] col_0;
    logic signed [DATA_W-1:0] col_1;
    logic signed [DATA_W-1:0] col_2;
    logic signed [DATA_W-1:0] col_3;
    logic                     last_row;

    modport source (output valid, row_index, col_0, col_1, col_2, col_3, last_row,
                    input ready);
    modport sink   (input valid, row_index, col_0, col_1, col_2, col_3, last_row,
                    output ready);
endinterface

/* sv/lav_norm.sv */
// ---------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: scale to [2^30, 2^31), sum of squares,
// one-bit-per-stage square root, one-bit-per-stage rounded division.
// ---------------------------------------------------------------------------
module lav_norm import lav_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int IN_W      = DATA_W + 1,
    parameter int SB_W      = 3 * DATA_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [IN_W-1:0]     in_vec [3],
    input  logic [SB_W-1:0]            in_sb,
    output logic                       out_valid,
    output logic signed [FRAC_BITS+1:0] out_vec [3],
    output logic [SB_W-1:0]            out_sb
);

    localparam int MAG_W  = 31;
    localparam int POS_W  = $clog2(IN_W);
    localparam int SH_W   = IN_W + MAG_W - 1;
    localparam int SQP_W  = 2 * MAG_W;
    localparam int SUM_W  = SQP_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 4;
    localparam int QW     = FRAC_BITS + 1;
    localparam int DIV_W  = ROOT_W + FRAC_BITS + 1;
    localparam int OUT_W  = FRAC_BITS + 2;

    // ---------------- front stages ----------------
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IN_W-1:0]   mag1_reg [3];
    logic [IN_W-1:0]   mag2_reg [3];
    logic [IN_W-1:0]   top1_reg;
    logic [2:0]        neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [POS_W-1:0]  pos2_reg;
    logic              zero2_reg, zero3_reg, zero4_reg;
    logic [MAG_W-1:0]  m3_reg [3];
    logic [MAG_W-1:0]  m4_reg [3];
    logic [SQP_W-1:0]  sq4_reg [3];
    logic [SB_W-1:0]   sb1_reg, sb2_reg, sb3_reg, sb4_reg;

    logic [IN_W-1:0]   mag_c [3];
    logic [2:0]        neg_c;
    logic [IN_W-1:0]   top_c;
    logic [POS_W-1:0]  pos_c;
    logic [SH_W-1:0]   sh_c [3];

    // ---------------- square root stages ----------------
    logic [ROOT_W:0]   sq_v_reg;
    logic [SUM_W-1:0]  sq_n_reg    [0:ROOT_W];
    logic [SUM_W-1:0]  sq_n_next   [0:ROOT_W];
    logic [REM_W-1:0]  sq_rem_reg  [0:ROOT_W];
    logic [REM_W-1:0]  sq_rem_next [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root_next[0:ROOT_W];
    logic [MAG_W-1:0]  sq_m_reg    [0:ROOT_W][3];
    logic [MAG_W-1:0]  sq_m_next   [0:ROOT_W][3];
    logic [2:0]        sq_neg_reg  [0:ROOT_W];
    logic [2:0]        sq_neg_next [0:ROOT_W];
    logic [ROOT_W:0]   sq_zero_reg;
    logic [ROOT_W:0]   sq_zero_next;
    logic [SB_W-1:0]   sq_sb_reg   [0:ROOT_W];
    logic [SB_W-1:0]   sq_sb_next  [0:ROOT_W];

    // ---------------- divider stages ----------------
    logic [QW:0]       dv_v_reg;
    logic [DIV_W-1:0]  dv_rem_reg  [0:QW][3];
    logic [DIV_W-1:0]  dv_rem_next [0:QW][3];
    logic [QW-1:0]     dv_q_reg    [0:QW][3];
    logic [QW-1:0]     dv_q_next   [0:QW][3];
    logic [ROOT_W-1:0] dv_len_reg  [0:QW];
    logic [ROOT_W-1:0] dv_len_next [0:QW];
    logic [2:0]        dv_neg_reg  [0:QW];
    logic [2:0]        dv_neg_next [0:QW];
    logic [QW:0]       dv_zero_reg;
    logic [QW:0]       dv_zero_next;
    logic [SB_W-1:0]   dv_sb_reg   [0:QW];
    logic [SB_W-1:0]   dv_sb_next  [0:QW];

    logic                    vo_reg;
    logic signed [OUT_W-1:0] out_reg [3];
    logic [SB_W-1:0]         sbo_reg;

    // magnitudes and largest one
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_c[i] = in_vec[i][IN_W-1];
            mag_c[i] = neg_c[i] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
        end
        top_c = mag_c[0];
        if (mag_c[1] > top_c)
            top_c = mag_c[1];
        if (mag_c[2] > top_c)
            top_c = mag_c[2];
    end

    // leading one position
    always_comb
    begin
        pos_c = '0;
        for (int b = 0; b < IN_W; b++)
        begin
            if (top1_reg[b])
                pos_c = POS_W'(b);
        end
    end

    // move the leading one to bit 30; right shifts drop low bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sh_c[i] = {mag2_reg[i], {(MAG_W-1){1'b0}}} >> pos2_reg;
    end

    // restoring square root, two radicand bits per stage
    always_comb
    begin
        logic [REM_W-1:0] rin;
        logic [REM_W-1:0] tst;
        sq_n_next[0]    = SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        sq_m_next[0]    = m4_reg;
        sq_neg_next[0]  = neg4_reg;
        sq_zero_next[0] = zero4_reg;
        sq_sb_next[0]   = sb4_reg;
        for (int k = 0; k < ROOT_W; k++)
        begin
            rin = {sq_rem_reg[k][REM_W-3:0], sq_n_reg[k][SUM_W-1:SUM_W-2]};
            tst = {{(REM_W-ROOT_W-2){1'b0}}, sq_root_reg[k], 2'b01};
            sq_n_next[k+1] = {sq_n_reg[k][SUM_W-3:0], 2'b00};
            if (rin >= tst)
            begin
                sq_rem_next[k+1]  = rin - tst;
                sq_root_next[k+1] = {sq_root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k+1]  = rin;
                sq_root_next[k+1] = {sq_root_reg[k][ROOT_W-2:0], 1'b0};
            end
            sq_m_next[k+1]    = sq_m_reg[k];
            sq_neg_next[k+1]  = sq_neg_reg[k];
            sq_zero_next[k+1] = sq_zero_reg[k];
            sq_sb_next[k+1]   = sq_sb_reg[k];
        end
    end

    // (m * 2^F + len/2) / len, one quotient bit per stage
    always_comb
    begin
        logic [DIV_W-1:0] dsub;
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_next[0][i] = DIV_W'({sq_m_reg[ROOT_W][i], {FRAC_BITS{1'b0}}})
                              + DIV_W'(sq_root_reg[ROOT_W] >> 1);
            dv_q_next[0][i]   = '0;
        end
        dv_len_next[0]  = sq_root_reg[ROOT_W];
        dv_neg_next[0]  = sq_neg_reg[ROOT_W];
        dv_zero_next[0] = sq_zero_reg[ROOT_W];
        dv_sb_next[0]   = sq_sb_reg[ROOT_W];
        for (int j = 0; j < QW; j++)
        begin
            dsub = DIV_W'(dv_len_reg[j]) << (QW - 1 - j);
            for (int i = 0; i < 3; i++)
            begin
                if (dv_rem_reg[j][i] >= dsub)
                begin
                    dv_rem_next[j+1][i] = dv_rem_reg[j][i] - dsub;
                    dv_q_next[j+1][i]   = {dv_q_reg[j][i][QW-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[j+1][i] = dv_rem_reg[j][i];
                    dv_q_next[j+1][i]   = {dv_q_reg[j][i][QW-2:0], 1'b0};
                end
            end
            dv_len_next[j+1]  = dv_len_reg[j];
            dv_neg_next[j+1]  = dv_neg_reg[j];
            dv_zero_next[j+1] = dv_zero_reg[j];
            dv_sb_next[j+1]   = dv_sb_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            sq_v_reg <= '0;
            dv_v_reg <= '0;
            vo_reg   <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            sq_v_reg <= {sq_v_reg[ROOT_W-1:0], v4_reg};
            dv_v_reg <= {dv_v_reg[QW-1:0], sq_v_reg[ROOT_W]};
            vo_reg   <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag_c;
            neg1_reg  <= neg_c;
            top1_reg  <= top_c;
            sb1_reg   <= in_sb;

            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            pos2_reg  <= pos_c;
            zero2_reg <= (top1_reg == '0);
            sb2_reg   <= sb1_reg;

            for (int i = 0; i < 3; i++)
                m3_reg[i] <= sh_c[i][MAG_W-1:0];
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
            sb3_reg   <= sb2_reg;

            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= SQP_W'(m3_reg[i]) * SQP_W'(m3_reg[i]);
            m4_reg    <= m3_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            sb4_reg   <= sb3_reg;

            sq_n_reg    <= sq_n_next;
            sq_rem_reg  <= sq_rem_next;
            sq_root_reg <= sq_root_next;
            sq_m_reg    <= sq_m_next;
            sq_neg_reg  <= sq_neg_next;
            sq_zero_reg <= sq_zero_next;
            sq_sb_reg   <= sq_sb_next;

            dv_rem_reg  <= dv_rem_next;
            dv_q_reg    <= dv_q_next;
            dv_len_reg  <= dv_len_next;
            dv_neg_reg  <= dv_neg_next;
            dv_zero_reg <= dv_zero_next;
            dv_sb_reg   <= dv_sb_next;

            // zero vector passes through as zero
            for (int i = 0; i < 3; i++)
            begin
                if (dv_zero_reg[QW])
                    out_reg[i] <= '0;
                else if (dv_neg_reg[QW][i])
                    out_reg[i] <= -OUT_W'(dv_q_reg[QW][i]);
                else
                    out_reg[i] <= OUT_W'(dv_q_reg[QW][i]);
            end
            sbo_reg <= dv_sb_reg[QW];
        end
    end

    assign out_valid = vo_reg;
    assign out_vec   = out_reg;
    assign out_sb    = sbo_reg;

endmodule

/* sv/lav_frame.sv */
// ---------------------------------------------------------------------------
// lav_frame
// Up vector and translation terms from the unit right and forward vectors;
// packs rows 0..2 of the view matrix.
// ---------------------------------------------------------------------------
module lav_frame import lav_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [FRAC_BITS+1:0] r [3],
    input  logic signed [FRAC_BITS+1:0] f [3],
    input  logic signed [DATA_W-1:0]    eye [3],
    output logic                        out_valid,
    output frame_t                      frame
);

    localparam int OUT_W = FRAC_BITS + 2;
    localparam int PW    = 2 * OUT_W;
    localparam int UW    = PW + 1 - FRAC_BITS;
    localparam int DRW   = OUT_W + DATA_W;
    localparam int DUW   = UW + DATA_W;
    localparam int ACC_W = FRAC_BITS + 40;
    localparam int SAT_W = ACC_W - FRAC_BITS;

    localparam logic signed [PW:0]      HALF_P = (PW+1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(1) << (FRAC_BITS - 1);

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-DATA_W:0] hi;
        hi = v[SAT_W-1:DATA_W-1];
        if (hi == '0 || hi == '1)
            return v[DATA_W-1:0];
        else if (v[SAT_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PW-1:0]     px1_reg [6];
    logic signed [DRW-1:0]    dr1_reg [3];
    logic signed [DRW-1:0]    df1_reg [3];
    logic signed [OUT_W-1:0]  r1_reg [3];
    logic signed [OUT_W-1:0]  r2_reg [3];
    logic signed [OUT_W-1:0]  r3_reg [3];
    logic signed [OUT_W-1:0]  f1_reg [3];
    logic signed [OUT_W-1:0]  f2_reg [3];
    logic signed [OUT_W-1:0]  f3_reg [3];
    logic signed [DATA_W-1:0] eye1_reg [3];
    logic signed [DATA_W-1:0] eye2_reg [3];
    logic signed [UW-1:0]     u2_reg [3];
    logic signed [UW-1:0]     u3_reg [3];
    logic signed [DATA_W-1:0] tr2_reg, tf2_reg, tr3_reg, tf3_reg;
    logic signed [DUW-1:0]    du3_reg [3];
    frame_t                   frame_reg;

    logic signed [PW:0]       ud_c [3];
    logic signed [ACC_W-1:0]  accr_c, accf_c, accu_c;

    always_comb
    begin
        ud_c[0] = (PW+1)'(px1_reg[0]) - (PW+1)'(px1_reg[1]) + HALF_P;
        ud_c[1] = (PW+1)'(px1_reg[2]) - (PW+1)'(px1_reg[3]) + HALF_P;
        ud_c[2] = (PW+1)'(px1_reg[4]) - (PW+1)'(px1_reg[5]) + HALF_P;
        // sign goes on before rounding
        accr_c = -(ACC_W'(dr1_reg[0]) + ACC_W'(dr1_reg[1]) + ACC_W'(dr1_reg[2])) + HALF_A;
        accf_c = ACC_W'(df1_reg[0]) + ACC_W'(df1_reg[1]) + ACC_W'(df1_reg[2]) + HALF_A;
        accu_c = -(ACC_W'(du3_reg[0]) + ACC_W'(du3_reg[1]) + ACC_W'(du3_reg[2])) + HALF_A;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // cross product terms and dot products with the eye
            px1_reg[0] <= PW'(r[1]) * PW'(f[2]);
            px1_reg[1] <= PW'(r[2]) * PW'(f[1]);
            px1_reg[2] <= PW'(r[2]) * PW'(f[0]);
            px1_reg[3] <= PW'(r[0]) * PW'(f[2]);
            px1_reg[4] <= PW'(r[0]) * PW'(f[1]);
            px1_reg[5] <= PW'(r[1]) * PW'(f[0]);
            for (int i = 0; i < 3; i++)
            begin
                dr1_reg[i] <= DRW'(r[i]) * DRW'(eye[i]);
                df1_reg[i] <= DRW'(f[i]) * DRW'(eye[i]);
            end
            r1_reg   <= r;
            f1_reg   <= f;
            eye1_reg <= eye;

            for (int i = 0; i < 3; i++)
                u2_reg[i] <= ud_c[i][PW:FRAC_BITS];
            tr2_reg  <= sat32(accr_c[ACC_W-1:FRAC_BITS]);
            tf2_reg  <= sat32(accf_c[ACC_W-1:FRAC_BITS]);
            r2_reg   <= r1_reg;
            f2_reg   <= f1_reg;
            eye2_reg <= eye1_reg;

            for (int i = 0; i < 3; i++)
                du3_reg[i] <= DUW'(u2_reg[i]) * DUW'(eye2_reg[i]);
            u3_reg  <= u2_reg;
            r3_reg  <= r2_reg;
            f3_reg  <= f2_reg;
            tr3_reg <= tr2_reg;
            tf3_reg <= tf2_reg;

            for (int i = 0; i < 3; i++)
            begin
                frame_reg.ent[0][i] <= DATA_W'(r3_reg[i]);
                frame_reg.ent[1][i] <= DATA_W'(u3_reg[i]);
                frame_reg.ent[2][i] <= -DATA_W'(f3_reg[i]);
            end
            frame_reg.ent[0][3] <= tr3_reg;
            frame_reg.ent[1][3] <= sat32(accu_c[ACC_W-1:FRAC_BITS]);
            frame_reg.ent[2][3] <= tf3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign frame     = frame_reg;

endmodule

/* sv/lav_rows.sv */
// ---------------------------------------------------------------------------
// lav_rows
// Output stage: holds one matrix and sends it as four row transfers.
// ---------------------------------------------------------------------------
module lav_rows import lav_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  frame_t     in_frame,
    output logic       take,
    lav_out_if.source  mat
);

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_BACK  = 2'd2;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    logic                    busy_reg;
    logic [1:0]              row_reg;
    frame_t                  frame_reg;
    logic [3:0][DATA_W-1:0]  sel;

    // free, or the last row goes out this cycle
    assign take = !busy_reg || (mat.ready && row_reg == ROW_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= ROW_RIGHT;
        end
        else if (take)
        begin
            busy_reg <= in_valid;
            row_reg  <= ROW_RIGHT;
        end
        else if (mat.ready)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
            frame_reg <= in_frame;
    end

    always_comb
    begin
        unique case (row_reg)
            ROW_RIGHT: sel = frame_reg.ent[0];
            ROW_UP:    sel = frame_reg.ent[1];
            ROW_BACK:  sel = frame_reg.ent[2];
            ROW_LAST:  sel = {ONE, {(3*DATA_W){1'b0}}};
            default:   sel = {ONE, {(3*DATA_W){1'b0}}};
        endcase
    end

    assign mat.valid     = busy_reg;
    assign mat.row_index = row_reg;
    assign mat.col_0     = sel[0];
    assign mat.col_1     = sel[1];
    assign mat.col_2     = sel[2];
    assign mat.col_3     = sel[3];
    assign mat.last_row  = (row_reg == ROW_LAST);

endmodule

/* sv/look_at_view_matrix.sv */
// ---------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in signed fixed point.
// ---------------------------------------------------------------------------
// Channel cam takes an eye point and a target point per transfer. Channel
// mat returns four row transfers per item, row_index 0..3: right, up and
// negated forward with translation in col_3, then 0,0,0,1; last_row marks
// row 3. Both use valid/ready; a transfer happens when both are high.
// The two normalizers make up most of the pipe: 32 square-root stages and
// FRAC_BITS+1 divide stages each. The output stage sends the four rows of
// an item one by one and takes the next matrix as the last row leaves;
// items may enter back to back until the pipe fills. While a finished
// matrix waits on the output stage, the whole pipe holds and cam.ready
// drops; nothing is lost or repeated. Reset clears all valid bits and the
// output stage; the block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lav_in_if.sink    cam,
    lav_out_if.source mat
);

    localparam int D_W    = DATA_W + 1;
    localparam int OUT_W  = FRAC_BITS + 2;
    localparam int SQW    = 2 * OUT_W;
    localparam int RS_W   = SQW + 1;
    localparam int EYE_W  = 3 * DATA_W;
    localparam int SB2_W  = EYE_W + 3 * OUT_W;
    localparam logic [63:0] EPS =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd99999999) / 64'd100000000;

    logic en, rows_take, frame_valid;
    frame_t frame;

    assign en        = rows_take || !frame_valid;
    assign cam.ready = en;

    // forward = target - eye
    logic                     v0_reg;
    logic signed [D_W-1:0]    d_reg [3];
    logic [EYE_W-1:0]         eye0_reg;

    logic                     n1_valid;
    logic signed [OUT_W-1:0]  n1_vec [3];
    logic [EYE_W-1:0]         n1_sb;

    logic                     va_reg, vb_reg;
    logic signed [OUT_W-1:0]  fa_reg [3];
    logic signed [OUT_W-1:0]  fb_reg [3];
    logic signed [OUT_W-1:0]  rb_reg [3];
    logic signed [SQW-1:0]    sqa_reg [2];
    logic [EYE_W-1:0]         eyea_reg, eyeb_reg;
    logic signed [RS_W-1:0]   rs_c;

    logic                     n2_valid;
    logic signed [OUT_W-1:0]  n2_vec [3];
    logic [SB2_W-1:0]         n2_sb;
    logic signed [OUT_W-1:0]  f2_c [3];
    logic signed [DATA_W-1:0] eye2_c [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= cam.valid;
            va_reg <= n1_valid;
            vb_reg <= va_reg;
        end
    end

    assign rs_c = RS_W'(sqa_reg[0]) + RS_W'(sqa_reg[1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= D_W'(cam.target_x) - D_W'(cam.eye_x);
            d_reg[1] <= D_W'(cam.target_y) - D_W'(cam.eye_y);
            d_reg[2] <= D_W'(cam.target_z) - D_W'(cam.eye_z);
            eye0_reg <= {cam.eye_x, cam.eye_y, cam.eye_z};

            // squared length of the primary right vector (-fz, 0, fx)
            sqa_reg[0] <= SQW'(n1_vec[0]) * SQW'(n1_vec[0]);
            sqa_reg[1] <= SQW'(n1_vec[2]) * SQW'(n1_vec[2]);
            fa_reg     <= n1_vec;
            eyea_reg   <= n1_sb;

            // near world up: fall back to forward x (0,0,1)
            if (64'(rs_c) < EPS)
            begin
                rb_reg[0] <= fa_reg[1];
                rb_reg[1] <= -fa_reg[0];
                rb_reg[2] <= '0;
            end
            else
            begin
                rb_reg[0] <= -fa_reg[2];
                rb_reg[1] <= '0;
                rb_reg[2] <= fa_reg[0];
            end
            fb_reg   <= fa_reg;
            eyeb_reg <= eyea_reg;
        end
    end

    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (D_W),
        .SB_W      (EYE_W)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .in_vec    (d_reg),
        .in_sb     (eye0_reg),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_sb    (n1_sb)
    );

    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (OUT_W),
        .SB_W      (SB2_W)
    ) u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg),
        .in_vec    (rb_reg),
        .in_sb     ({eyeb_reg, fb_reg[0], fb_reg[1], fb_reg[2]}),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_sb    (n2_sb)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye2_c[i] = n2_sb[SB2_W-1-i*DATA_W -: DATA_W];
            f2_c[i]   = n2_sb[3*OUT_W-1-i*OUT_W -: OUT_W];
        end
    end

    lav_frame #(
        .FRAC_BITS (FRAC_BITS)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n2_valid),
        .r         (n2_vec),
        .f         (f2_c),
        .eye       (eye2_c),
        .out_valid (frame_valid),
        .frame     (frame)
    );

    lav_rows #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rows (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame_valid),
        .in_frame  (frame),
        .take      (rows_take),
        .mat       (mat)
    );

endmodule

/* tb/tb_lav_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lav_if
// Note: the channel interfaces come with the RTL (sv/lav_if.sv); this file
// only holds the row record shared by the checker.
// ---------------------------------------------------------------------------
package tb_lav_pkg;
    import lav_pkg::*;

    typedef struct packed {
        logic [1:0]        row_index;
        logic [DATA_W-1:0] col_0;
        logic [DATA_W-1:0] col_1;
        logic [DATA_W-1:0] col_2;
        logic [DATA_W-1:0] col_3;
        logic              last_row;
    } mat_row_t;
endpackage

/* tb/tb_look_at_view_matrix.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_look_at_view_matrix
// Drives eye/target pairs into the look-at block and checks every matrix
// row against a local fixed-point predictor, under random idling on both
// channels for the directed pairs and the first two thirds of the random ones.
// ---------------------------------------------------------------------------
module tb_look_at_view_matrix;
    import lav_pkg::*;
    import tb_lav_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int N_RANDOM  = 190;
    localparam int CYC_LIMIT = 400000;
    localparam int HI = 32'sh7FFF_FFFF;
    localparam int LO = 32'sh8000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lav_in_if  cam ();
    lav_out_if mat ();

    look_at_view_matrix #(.FRAC_BITS(FB)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cam   (cam.sink),
        .mat   (mat.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mat_row_t rows_due[$];
    int       errors    = 0;
    int       rows_seen = 0;
    int       cycles    = 0;
    int       src_idle  = 0;
    int       snk_idle  = 0;
    int       n_items   = 0;

    // ---------------- predictor ----------------
    function automatic longint rnd_frac(longint v);
        longint h;
        h = v + (64'sd1 <<< (FB - 1));
        return h >>> FB;
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic unit_vec(inout longint v[3]);
        longint unsigned m[3];
        longint unsigned top, len, q;
        bit neg[3];
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            m[i]   = neg[i] ? -v[i] : v[i];
        end
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        if (top == 0)
            return;
        while (top >= (64'd1 << 31))
        begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (top < (64'd1 << 30))
        begin
            top = top << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            q    = ((m[i] << FB) + (len >> 1)) / len;
            v[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endtask

    function automatic mat_row_t mk_row(int idx, longint a, longint b, longint c,
                                        longint d);
        mat_row_t r;
        r.row_index = idx[1:0];
        r.col_0     = sat32(a);
        r.col_1     = sat32(b);
        r.col_2     = sat32(c);
        r.col_3     = sat32(d);
        r.last_row  = (idx == 3);
        return r;
    endfunction

    task automatic predict_view(input logic [31:0] pt[6]);
        longint eye[3], f[3], rt[3], up[3];
        longint unsigned rs, eps;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'(signed'(pt[i]));
            f[i]   = longint'(signed'(pt[i+3])) - eye[i];
        end
        unit_vec(f);
        rt[0] = -f[2]; rt[1] = 0; rt[2] = f[0];
        rs  = rt[0] * rt[0] + rt[2] * rt[2];
        eps = ((64'd1 << (2 * FB)) + 99999999) / 100000000;
        // forward along world up: fall back to the z axis
        if (rs < eps)
        begin
            rt[0] = f[1]; rt[1] = -f[0]; rt[2] = 0;
        end
        unit_vec(rt);
        up[0] = rnd_frac(rt[1] * f[2] - rt[2] * f[1]);
        up[1] = rnd_frac(rt[2] * f[0] - rt[0] * f[2]);
        up[2] = rnd_frac(rt[0] * f[1] - rt[1] * f[0]);
        rows_due.push_back(mk_row(0, rt[0], rt[1], rt[2],
            rnd_frac(-(rt[0] * eye[0] + rt[1] * eye[1] + rt[2] * eye[2]))));
        rows_due.push_back(mk_row(1, up[0], up[1], up[2],
            rnd_frac(-(up[0] * eye[0] + up[1] * eye[1] + up[2] * eye[2]))));
        rows_due.push_back(mk_row(2, -f[0], -f[1], -f[2],
            rnd_frac(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2])));
        rows_due.push_back(mk_row(3, 0, 0, 0, 64'sd1 <<< FB));
    endtask

    // ---------------- sender ----------------
    initial
    begin
        cam.valid    = 1'b0;
        cam.eye_x    = '0;
        cam.eye_y    = '0;
        cam.eye_z    = '0;
        cam.target_x = '0;
        cam.target_y = '0;
        cam.target_z = '0;
        mat.ready    = 1'b0;
    end

    // valid stays high between back-to-back transfers; it drops only while idling and after the last item
    task automatic send_view(input logic [31:0] pt[6]);
        while (src_idle > 0 && $urandom_range(99) < src_idle)
        begin
            cam.valid <= 1'b0;
            @(posedge clk);
        end
        cam.valid    <= 1'b1;
        cam.eye_x    <= pt[0];
        cam.eye_y    <= pt[1];
        cam.eye_z    <= pt[2];
        cam.target_x <= pt[3];
        cam.target_y <= pt[4];
        cam.target_z <= pt[5];
        @(posedge clk);
        while (!cam.ready)
            @(posedge clk);
        predict_view(pt);
        n_items++;
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            2: return {{8{1'b0}}, 24'($urandom())} - 32'h0080_0000;
            default: return ($urandom_range(1) != 0) ? HI : LO;
        endcase
    endfunction

    initial
    begin
        logic [31:0] pt[6];
        // directed rows: eye xyz, target xyz
        logic [31:0] plan[20][6];
        int mode;
        int small_step;
        plan[0]  = '{0, 0, 0, 0, 0, 0};                         // eye equals target
        plan[1]  = '{0, 0, 0, 0, 0, -32'sh10000};               // look down -z
        plan[2]  = '{0, 0, 0, 0, 32'sh10000, 0};                // forward on world up
        plan[3]  = '{0, 0, 0, 0, -32'sh10000, 0};               // straight down
        plan[4]  = '{0, 0, 0, 1, 0, 0};                         // one-LSB forward
        plan[5]  = '{0, 0, 0, 0, 1, 0};                         // one-LSB up
        plan[6]  = '{LO, LO, LO, HI, HI, HI};                   // widest span
        plan[7]  = '{HI, HI, HI, LO, LO, LO};
        plan[8]  = '{HI, 0, 0, LO, 0, 0};
        plan[9]  = '{0, LO, 0, 0, HI, 0};
        plan[10] = '{0, 0, HI, 0, 0, LO};
        plan[11] = '{HI, HI, HI, HI, HI, LO};                   // translation saturates
        plan[12] = '{LO, LO, LO, LO, HI, LO};
        plan[13] = '{32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0};
        plan[14] = '{0, 0, 0, 1, 32'sh7FFF0000, 0};              // nearly vertical
        plan[15] = '{0, 0, 0, -1, 32'sh7FFF0000, 1};
        plan[16] = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
        plan[17] = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
        plan[18] = '{32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1};
        plan[19] = '{-32'sh30000, 32'sh8000, 32'sh50000, 32'sh10000, 0, -32'sh20000};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle = 25;
        snk_idle = 48;
        for (int k = 0; k < 20; k++)
            send_view(plan[k]);

        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == N_RANDOM / 3)
            begin
                src_idle = 48;
                snk_idle = 25;
            end
            if (k == 2 * N_RANDOM / 3)
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            mode = $urandom_range(9);
            small_step = (mode >= 7);
            for (int i = 0; i < 3; i++)
                pt[i] = rnd_coord(mode % 4);
            for (int i = 3; i < 6; i++)
            begin
                if (small_step)
                    pt[i] = pt[i-3] + $urandom_range(0, 4) - 2;  // tiny forward
                else if (mode == 6 && i != 4)
                    pt[i] = pt[i-3];                               // vertical forward
                else
                    pt[i] = rnd_coord(mode % 4);
            end
            send_view(pt);
        end
        cam.valid <= 1'b0;

        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d camera pairs (directed extremes, vertical and tiny forwards,",
                 n_items);
        $display("random spans) and checked %0d matrix rows.", rows_seen);
        if (errors == 0)
            $display("PASS look_at_view_matrix");
        else
            $display("FAIL look_at_view_matrix");
        $finish;
    end

    // ---------------- receiver and checker ----------------
    always @(posedge clk)
    begin
        mat_row_t got;
        mat_row_t want;
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("FAIL look_at_view_matrix");
            $finish;
        end
        if (rst_n)
            mat.ready <= !(snk_idle > 0 && $urandom_range(99) < snk_idle);
        if (rst_n && mat.valid && mat.ready)
        begin
            got = '{mat.row_index, mat.col_0, mat.col_1, mat.col_2, mat.col_3,
                    mat.last_row};
            rows_seen++;
            if (rows_due.size() == 0)
            begin
                $display("%0t: unexpected row transfer %h", $time, got);
                errors++;
            end
            else
            begin
                want = rows_due.pop_front();
                if (got.row_index !== want.row_index || got.last_row !== want.last_row)
                begin
                    $display("%0t: row/last exp %0d/%0d got %0d/%0d", $time,
                             want.row_index, want.last_row, got.row_index, got.last_row);
                    errors++;
                end
                if (got.col_0 !== want.col_0 || got.col_1 !== want.col_1 ||
                    got.col_2 !== want.col_2 || got.col_3 !== want.col_3)
                begin
                    $display("%0t: row %0d cols exp %h %h %h %h got %h %h %h %h", $time,
                             want.row_index, want.col_0, want.col_1, want.col_2,
                             want.col_3, got.col_0, got.col_1, got.col_2, got.col_3);
                    errors++;
                end
            end
        end
    end

endmodule
